>>> design/map_pkg.sv
package map_pkg;

    localparam int DEFAULT_WINDOW_DEPTH = 1024;
    localparam int DEFAULT_SAMPLE_BITS  = 16;

    localparam int MEAN_W          = 32;
    localparam int CFG_DATA_W      = 32;
    localparam int PADDR_W         = 3;
    localparam int WINDOW_LENGTH_W = 11;

    localparam logic [WINDOW_LENGTH_W-1:0] WINDOW_LENGTH_RESET = 11'd64;

    localparam logic [PADDR_W-3:0] REG_WINDOW_LENGTH = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_ADD,
        ST_ABS,
        ST_DIV,
        ST_OUT
    } state_t;

    // zero means one, anything above the depth saturates
    function automatic int unsigned eff_len(logic [WINDOW_LENGTH_W-1:0] wl,
                                            int unsigned depth);
        int unsigned len;
        len = int'(wl);
        if (len == 0)
        begin
            len = 1;
        end
        else if (len > depth)
        begin
            len = depth;
        end
        return len;
    endfunction

endpackage

>>> design/map_divider.sv
module map_divider #(
    parameter int WINDOW_DEPTH = map_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = map_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [2*SAMPLE_BITS+$clog2(WINDOW_DEPTH)-1:0]     dividend,
    input  logic [$clog2(WINDOW_DEPTH+1)-1:0]                 divisor,
    output logic                                              done,
    output logic [2*SAMPLE_BITS-2:0]                          quotient
);
    import map_pkg::*;

    localparam int QUO_W = 2*SAMPLE_BITS - 1;
    localparam int LEN_W = $clog2(WINDOW_DEPTH+1);
    localparam int CNT_W = $clog2(QUO_W+1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [LEN_W-1:0]    rem_next;
    logic [QUO_W-1:0]    quo_reg;
    logic [QUO_W-1:0]    quo_next;
    logic [LEN_W:0]      shifted;
    logic [LEN_W:0]      trial;
    logic                ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[QUO_W-1]};
        trial    = shifted - {1'b0, divisor};
        ge       = (shifted >= {1'b0, divisor});
        rem_next = ge ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // upper dividend bits are known to be below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[QUO_W +: LEN_W];
            quo_reg <= dividend[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/moving_average_power_top.sv
// an input beat passes the bit-serial multiply, the subtract of the oldest product, the add
// of the new product with the ring write, the absolute value of the sum and the bit-serial
// divide before it reaches the output register; no new input beat is taken until then
// a finished result waits in the output register while the next beat is taken
// reset is asynchronous; the ring reads as zero through a fill count, no clearing pass
module moving_average_power_top #(
    parameter int WINDOW_DEPTH = map_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = map_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // current_sample, voltage_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic                                     s_tlast,
    // mean_power
    output logic [map_pkg::MEAN_W-1:0]               m_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic                                     m_tlast,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [map_pkg::PADDR_W-1:0]              paddr,
    input  logic [map_pkg::CFG_DATA_W-1:0]           pwdata,
    output logic [map_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                     pready
);
    import map_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PROD_W = 2*SB;
    localparam int SUM_W = PROD_W + $clog2(WINDOW_DEPTH);
    localparam int QUO_W = PROD_W - 1;
    localparam int LEN_W = $clog2(WINDOW_DEPTH+1);
    localparam int POS_W = $clog2(WINDOW_DEPTH);
    localparam int MCNT_W = $clog2(SB);
    localparam int EXT_W = (QUO_W+1 > MEAN_W) ? QUO_W+1 : MEAN_W;

    state_t                      state_reg;
    state_t                      state_next;

    logic [WINDOW_LENGTH_W-1:0]  wl_reg;
    logic [LEN_W-1:0]            len_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [LEN_W-1:0]            fill_reg;
    logic signed [SUM_W-1:0]     sum_reg;

    logic [SB-1:0]               mcand_reg;
    logic [SB-1:0]               mhi_reg;
    logic [SB-1:0]               mlo_reg;
    logic [MCNT_W-1:0]           mcnt_reg;
    logic                        neg_reg;
    logic                        last_reg;
    logic                        old_valid_reg;
    logic [PROD_W-1:0]           rd_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic                        sneg_reg;

    logic                        out_valid_reg;
    logic [MEAN_W-1:0]           out_data_reg;
    logic                        out_last_reg;

    logic [PROD_W-1:0]           ring [WINDOW_DEPTH];

    logic                        in_beat;
    logic                        cfg_wr;
    logic                        div_start;
    logic                        div_done;
    logic                        ring_wr;
    logic                        out_load;
    logic [QUO_W-1:0]            quotient;

    logic [SB-1:0]               cur;
    logic [SB-1:0]               volt;
    logic [SB-1:0]               cur_abs;
    logic [SB-1:0]               volt_abs;
    logic [SB:0]                 mul_sum;
    logic [PROD_W-1:0]           mag;
    logic signed [SUM_W-1:0]     old_ext;
    logic [SUM_W-1:0]            sum_abs;
    logic [POS_W-1:0]            pos_inc;
    logic signed [QUO_W:0]       q_signed;
    logic signed [EXT_W-1:0]     q_ext;

    assign in_beat = s_tvalid && s_tready;
    assign cfg_wr  = psel && penable && pwrite && pready
                     && (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH);

    assign cur      = s_tdata[SB-1:0];
    assign volt     = s_tdata[2*SB-1:SB];
    assign cur_abs  = cur[SB-1] ? (~cur + 1'b1) : cur;
    assign volt_abs = volt[SB-1] ? (~volt + 1'b1) : volt;

    // shift-add step of the unsigned magnitude product
    assign mul_sum = {1'b0, mhi_reg} + (mlo_reg[0] ? {1'b0, mcand_reg} : '0);
    assign mag     = {mhi_reg, mlo_reg};

    assign old_ext = old_valid_reg ? SUM_W'(signed'(rd_reg)) : '0;
    assign sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign pos_inc = (LEN_W'(pos_reg) + 1'b1 == len_reg) ? '0 : pos_reg + 1'b1;

    assign q_signed = sneg_reg ? -signed'({1'b0, quotient}) : signed'({1'b0, quotient});
    assign q_ext    = EXT_W'(q_signed);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mcnt_reg == '0)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_ABS;
            ST_ABS:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        ring_wr   = (state_reg == ST_ADD);
        div_start = (state_reg == ST_ABS);
        out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wl_reg        <= WINDOW_LENGTH_RESET;
            len_reg       <= LEN_W'(eff_len(WINDOW_LENGTH_RESET, WINDOW_DEPTH));
            pos_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                wl_reg   <= pwdata[WINDOW_LENGTH_W-1:0];
                len_reg  <= LEN_W'(eff_len(pwdata[WINDOW_LENGTH_W-1:0], WINDOW_DEPTH));
                pos_reg  <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            else if (state_reg == ST_SUB)
            begin
                sum_reg <= sum_reg - old_ext;
            end
            else if (state_reg == ST_ADD)
            begin
                sum_reg <= sum_reg + SUM_W'(prod_reg);
                pos_reg <= pos_inc;
                if (fill_reg < len_reg)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (state_reg == ST_ABS && last_reg)
            begin
                // end of run, start over from an empty window
                pos_reg  <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            mcand_reg     <= cur_abs;
            mhi_reg       <= '0;
            mlo_reg       <= volt_abs;
            mcnt_reg      <= MCNT_W'(SB-1);
            neg_reg       <= cur[SB-1] ^ volt[SB-1];
            last_reg      <= s_tlast;
            old_valid_reg <= (LEN_W'(pos_reg) < fill_reg);
        end
        else if (state_reg == ST_MUL)
        begin
            mhi_reg  <= mul_sum[SB:1];
            mlo_reg  <= {mul_sum[0], mlo_reg[SB-1:1]};
            mcnt_reg <= mcnt_reg - 1'b1;
        end

        if (state_reg == ST_SUB)
        begin
            prod_reg <= neg_reg ? -signed'(mag) : signed'(mag);
        end

        if (state_reg == ST_ABS)
        begin
            sneg_reg <= sum_reg[SUM_W-1];
        end

        if (out_load)
        begin
            out_data_reg <= q_ext[MEAN_W-1:0];
            out_last_reg <= last_reg;
        end
    end

    // product ring, one read at accept and one write per beat
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            rd_reg <= ring[pos_reg];
        end
        if (ring_wr)
        begin
            ring[pos_reg] <= prod_reg;
        end
    end

    map_divider #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_abs),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH)
                    ? CFG_DATA_W'(wl_reg) : '0;

endmodule

>>> design/map_checker.sv
module map_checker #(
    parameter int SAMPLE_BITS = map_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                     s_tvalid,
    input  logic                                     s_tready,
    input  logic                                     s_tlast,
    input  logic [map_pkg::MEAN_W-1:0]               m_tdata,
    input  logic                                     m_tvalid,
    input  logic                                     m_tready,
    input  logic                                     m_tlast,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [map_pkg::PADDR_W-1:0]              paddr,
    input  logic [map_pkg::CFG_DATA_W-1:0]           pwdata,
    input  logic [map_pkg::CFG_DATA_W-1:0]           prdata,
    input  logic                                     pready
);
    import map_pkg::*;

    // a stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // one item in flight, no input beat on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // a new result never follows its input beat at once
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too early");

    // window length reads back within its width
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata[CFG_DATA_W-1:WINDOW_LENGTH_W] == '0)
        else $error("register read has stray upper bits");

endmodule

bind moving_average_power_top map_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_map_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

>>> tb/sv/mean_power_checker.sv
`timescale 1ns / 1ps
module mean_power_checker #(
    parameter int DEPTH    = map_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_W = map_pkg::DEFAULT_SAMPLE_BITS,
    parameter int DATA_W   = ((2*SAMPLE_W+7)/8)*8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [DATA_W-1:0]                 s_tdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              s_tlast,
    input  logic [map_pkg::MEAN_W-1:0]        m_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [map_pkg::PADDR_W-1:0]       paddr,
    input  logic [map_pkg::CFG_DATA_W-1:0]    pwdata,
    input  logic [map_pkg::CFG_DATA_W-1:0]    prdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                waiting_count,
    output int                                checked_count
);

    import map_pkg::*;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic                     done;
    } power_beat_t;

    power_beat_t                pending_means[$];
    longint                     power_ring[DEPTH];
    int unsigned                slot;
    longint                     running_sum;
    logic [WINDOW_LENGTH_W-1:0] window_reg;

    initial
    begin
        fail_count    = 0;
        waiting_count = 0;
        checked_count = 0;
    end

    function automatic longint window_span();
        if (window_reg == '0)
        begin
            return 1;
        end
        if (int'(window_reg) > DEPTH)
        begin
            return DEPTH;
        end
        return longint'(window_reg);
    endfunction

    task automatic clear_ring();
        foreach (power_ring[i])
        begin
            power_ring[i] = 0;
        end
        slot        = 0;
        running_sum = 0;
    endtask

    task automatic accumulate_power(input logic signed [SAMPLE_W-1:0] cur,
                                    input logic signed [SAMPLE_W-1:0] volt,
                                    input logic last);
        longint      span;
        longint      product;
        int unsigned pos;
        power_beat_t beat;
        span = window_span();
        pos  = slot;
        if (pos >= span)
        begin
            pos = 0;
        end
        product         = longint'(cur) * longint'(volt);
        running_sum     = running_sum - power_ring[pos] + product;
        power_ring[pos] = product;
        pos++;
        slot      = (pos >= span) ? 0 : pos;
        beat.mean = MEAN_W'(running_sum / span);
        beat.done = last;
        pending_means.push_back(beat);
        if (last)
        begin
            clear_ring();
        end
    endtask

    always @(posedge clk)
    begin : watch
        power_beat_t want;
        if (!rst_n)
        begin
            clear_ring();
            window_reg = WINDOW_LENGTH_RESET;
            pending_means.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_means.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got mean %0d last %0b",
                             $time, $signed(m_tdata), m_tlast);
                end
                else
                begin
                    want = pending_means.pop_front();
                    checked_count++;
                    if (m_tdata !== want.mean)
                    begin
                        fail_count++;
                        $display("%0t: mean_power expected %0d, got %0d",
                                 $time, want.mean, $signed(m_tdata));
                    end
                    if (m_tlast !== want.done)
                    begin
                        fail_count++;
                        $display("%0t: run_done expected %0b, got %0b",
                                 $time, want.done, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                accumulate_power(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W], s_tlast);
            end
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH)
            begin
                if (pwrite)
                begin
                    window_reg = pwdata[WINDOW_LENGTH_W-1:0];
                    clear_ring();
                end
                else if (prdata !== CFG_DATA_W'(window_reg))
                begin
                    fail_count++;
                    $display("%0t: window_length read expected %0d, got %0d",
                             $time, window_reg, prdata);
                end
            end
        end
        waiting_count = pending_means.size();
    end

endmodule

>>> tb/sv/moving_average_power_top_tb.sv
`timescale 1ns / 1ps
module moving_average_power_top_tb;

    import map_pkg::*;

    localparam int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS;
    localparam int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH;
    localparam int DATA_W       = ((2*SAMPLE_BITS+7)/8)*8;
    localparam int LATENCY      = 3*SAMPLE_BITS + 5;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SAMPLE_GOAL  = 1800;
    localparam int PAD_W        = CFG_DATA_W - WINDOW_LENGTH_W;

    localparam logic [PADDR_W-3:0] REG_SPARE = ~REG_WINDOW_LENGTH;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_LONG_STALLS,
        READY_EVERY_THIRD
    } ready_mode_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic [DATA_W-1:0]     s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic                  s_tlast  = 1'b0;
    logic [MEAN_W-1:0]     m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [PADDR_W-1:0]    paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int waiting_count;
    int checked_count;

    int          cycles         = 0;
    int          samples_sent   = 0;
    int          runs_closed    = 0;
    int          windows_tried  = 0;
    int          burst_left     = 0;
    bit          steady_sender  = 1'b0;
    int          ready_epoch    = 0;
    int          stall_left     = 0;
    ready_mode_t ready_mode     = READY_ALWAYS;

    moving_average_power_top #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mean_power_checker #(
        .DEPTH    (WINDOW_DEPTH),
        .SAMPLE_W (SAMPLE_BITS),
        .DATA_W   (DATA_W)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tlast       (s_tlast),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tlast       (m_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .waiting_count (waiting_count),
        .checked_count (checked_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, waiting_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side back-pressure, switching at random among four ready patterns
    always @(negedge clk)
    begin
        if (ready_epoch == 0)
        begin
            ready_epoch = $urandom_range(200, 800);
            ready_mode  = ready_mode_t'($urandom_range(0, 3));
        end
        ready_epoch--;
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else
        begin
            case (ready_mode)
                READY_ALWAYS:
                begin
                    m_tready = 1'b1;
                end
                READY_COIN:
                begin
                    m_tready = 1'($urandom_range(0, 1));
                end
                READY_LONG_STALLS:
                begin
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(1, 60);
                        m_tready   = 1'b0;
                    end
                    else
                    begin
                        m_tready = 1'b1;
                    end
                end
                default:
                begin
                    m_tready = (ready_epoch % 3 == 0);
                end
            endcase
        end
    end

    function automatic int pick_sample();
        case ($urandom_range(0, 9))
            0:       return -(2 ** (SAMPLE_BITS-1));
            1:       return 2 ** (SAMPLE_BITS-1) - 1;
            2:       return 0;
            3:       return -1;
            4:       return int'($urandom_range(0, 64)) - 32;
            default: return int'($urandom_range(0, 2 ** SAMPLE_BITS - 1))
                            - 2 ** (SAMPLE_BITS-1);
        endcase
    endfunction

    task automatic send_sample(input int cur, input int volt, input logic last);
        s_tdata  = DATA_W'({SAMPLE_BITS'(volt), SAMPLE_BITS'(cur)});
        s_tlast  = last;
        s_tvalid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        @(negedge clk);
        samples_sent++;
        if (last)
        begin
            runs_closed++;
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!steady_sender)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(0, 40)) @(negedge clk);
            end
        end
    endtask

    task automatic run_samples(input int count, input int last_odds);
        for (int i = 0; i < count; i++)
        begin
            send_sample(pick_sample(), pick_sample(),
                        last_odds > 0 && $urandom_range(1, last_odds) == 1);
        end
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (waiting_count != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input logic [PADDR_W-3:0] index, input logic write,
                              input logic [CFG_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_window(input logic [WINDOW_LENGTH_W-1:0] length);
        settle();
        apb_access(REG_WINDOW_LENGTH, 1'b1, {PAD_W'($urandom), length});
        apb_access(REG_WINDOW_LENGTH, 1'b0, '0);
        windows_tried++;
        steady_sender = ($urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        logic [WINDOW_LENGTH_W-1:0] length;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset window of 64, ring starts empty
        apb_access(REG_WINDOW_LENGTH, 1'b0, '0);
        send_sample(0, 0, 1'b0);
        send_sample(32767, 32767, 1'b0);
        send_sample(-32768, -32768, 1'b0);
        send_sample(-32768, 32767, 1'b0);
        send_sample(32767, -32768, 1'b0);
        send_sample(-1, -1, 1'b0);
        send_sample(12345, -2, 1'b1);
        send_sample(-32768, -32768, 1'b1);
        // negative sums truncate toward zero
        send_sample(-1, 65, 1'b0);
        send_sample(1, -1, 1'b0);

        // spare address must not touch the window or the ring
        settle();
        apb_access(REG_SPARE, 1'b1, 32'h0000_0005);
        apb_access(REG_WINDOW_LENGTH, 1'b0, '0);
        send_sample(100, 100, 1'b0);
        send_sample(-7, 3, 1'b1);

        set_window(11'd1);
        send_sample(-32768, -32768, 1'b0);
        send_sample(32767, -32768, 1'b0);
        send_sample(7, -3, 1'b1);

        // zero behaves as a window of one
        set_window(11'd0);
        send_sample(-32768, -32768, 1'b0);
        send_sample(-5, 9, 1'b0);

        set_window(11'd2);
        send_sample(3, -1, 1'b0);
        send_sample(-32768, 32767, 1'b0);
        send_sample(-32768, 32767, 1'b0);
        send_sample(1, 1, 1'b1);

        // full depth, long enough to wrap the ring
        set_window(11'd1024);
        run_samples(WINDOW_DEPTH + 16, 0);
        send_sample(pick_sample(), pick_sample(), 1'b1);

        // above depth saturates
        set_window(11'd2047);
        run_samples(80, 30);

        set_window(11'd1023);
        run_samples(40, 0);

        while (samples_sent < SAMPLE_GOAL)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: length = WINDOW_LENGTH_W'($urandom_range(1, 16));
                5, 6, 7:       length = WINDOW_LENGTH_W'($urandom_range(17, 200));
                8:             length = WINDOW_LENGTH_W'($urandom_range(0, 1));
                default:       length = WINDOW_LENGTH_W'($urandom);
            endcase
            set_window(length);
            if ($urandom_range(0, 5) == 0)
            begin
                apb_access(REG_SPARE, 1'b1, $urandom);
            end
            run_samples($urandom_range(20, 120), $urandom_range(5, 60));
        end

        settle();
        repeat (LATENCY) @(negedge clk);
        $display("sent %0d samples in %0d closed runs over %0d window settings",
                 samples_sent, runs_closed, windows_tried);
        $display("checked %0d mean power beats, %0d mismatches", checked_count, fail_count);
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
design/map_pkg.sv
design/map_divider.sv
design/moving_average_power_top.sv
design/map_checker.sv
tb/sv/mean_power_checker.sv
tb/sv/moving_average_power_top_tb.sv
